### design/blcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blcm_pkg;

    // Default history depth, in entries.
    localparam int HISTORY_DEPTH_DEF = 128;

    // Width of one history entry: percent, charging flag, timestamp.
    localparam int ENTRY_PCT_W = 7;
    localparam int ENTRY_TS_W  = 32;
    localparam int ENTRY_W     = ENTRY_PCT_W + 1 + ENTRY_TS_W;

    localparam int LOW_LEVEL_LIMIT = 20;
    localparam int LEVEL_MAX       = 100;
    localparam logic [7:0] NO_LEVEL = 8'hFF;

    localparam logic [31:0] MIN_INTERVAL = 32'd1000;
    localparam logic [6:0]  MIN_THRESHOLD = 7'd1;

    localparam logic [31:0] RST_NORMAL_INTERVAL   = 32'd60000;
    localparam logic [6:0]  RST_NORMAL_THRESHOLD  = 7'd1;
    localparam logic [31:0] RST_LOW_INTERVAL      = 32'd300000;
    localparam logic [6:0]  RST_LOW_THRESHOLD     = 7'd2;
    localparam logic [31:0] RST_CHARGE_INTERVAL   = 32'd5000;
    localparam logic [6:0]  RST_CHARGE_THRESHOLD  = 7'd1;

    typedef enum logic [2:0] {
        CFG_NORMAL_INTERVAL  = 3'd0,
        CFG_NORMAL_THRESHOLD = 3'd1,
        CFG_LOW_INTERVAL     = 3'd2,
        CFG_LOW_THRESHOLD    = 3'd3,
        CFG_CHARGE_INTERVAL  = 3'd4,
        CFG_CHARGE_THRESHOLD = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_LOW      = 2'd1,
        MODE_CHARGING = 2'd2
    } t_mode;

    typedef enum logic {
        REQ_REPORT = 1'b0,
        REQ_READ   = 1'b1
    } t_req;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Configuration registers, one slot per mode (normal, low power, charging).
    typedef struct packed {
        logic [2:0][31:0] interval;
        logic [2:0][6:0]  threshold;
    } t_cfg;

    function automatic logic [31:0] mode_interval(t_cfg cfg, t_mode mode);
        logic [31:0] v;
        unique case (mode)
            MODE_LOW:      v = cfg.interval[1];
            MODE_CHARGING: v = cfg.interval[2];
            default:       v = cfg.interval[0];
        endcase
        return v;
    endfunction

    function automatic logic [6:0] mode_threshold(t_cfg cfg, t_mode mode);
        logic [6:0] v;
        unique case (mode)
            MODE_LOW:      v = cfg.threshold[1];
            MODE_CHARGING: v = cfg.threshold[2];
            default:       v = cfg.threshold[0];
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/blcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module blcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/blcm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module blcm_cfg
    import blcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    logic [31:0] w_interval;
    logic [6:0]  w_threshold;

    // Intervals are held at no less than the minimum, thresholds at no less than one.
    assign w_interval  = (i_cfg_data < MIN_INTERVAL) ? MIN_INTERVAL : i_cfg_data;
    assign w_threshold = (i_cfg_data[6:0] == 7'd0) ? MIN_THRESHOLD : i_cfg_data[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval[0]  <= RST_NORMAL_INTERVAL;
            r_cfg.threshold[0] <= RST_NORMAL_THRESHOLD;
            r_cfg.interval[1]  <= RST_LOW_INTERVAL;
            r_cfg.threshold[1] <= RST_LOW_THRESHOLD;
            r_cfg.interval[2]  <= RST_CHARGE_INTERVAL;
            r_cfg.threshold[2] <= RST_CHARGE_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NORMAL_INTERVAL:  r_cfg.interval[0]  <= w_interval;
                CFG_NORMAL_THRESHOLD: r_cfg.threshold[0] <= w_threshold;
                CFG_LOW_INTERVAL:     r_cfg.interval[1]  <= w_interval;
                CFG_LOW_THRESHOLD:    r_cfg.threshold[1] <= w_threshold;
                CFG_CHARGE_INTERVAL:  r_cfg.interval[2]  <= w_interval;
                CFG_CHARGE_THRESHOLD: r_cfg.threshold[2] <= w_threshold;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/battery_level_change_monitor.sv
// Battery level change monitor.
// Requests arrive on the s_axis channel: tuser selects a battery report (0) or a history
// read (1); tdata carries the percent, charging flag, timestamp and history index.
// A report in the range 0..100 updates the mode, may raise a change event, and is
// appended to a ring history in a simple dual-port synchronous memory unless its percent
// and charging flag repeat the newest entry. A history read returns the entry at an
// oldest-first index. Every request produces exactly one result transfer on m_axis.
// In the acceptance cycle the history memory is read (newest entry for a report,
// requested entry for a read); in the execute state the read data is combined with the
// request, the memory is written back and the result register is loaded. A new request
// is not taken until the current one has loaded its result. A write always lands
// before the next read is issued, so no forwarding is needed.
// The result sits in an output register, so a new request is taken while a result
// waits; if the receiver still stalls when the next result is ready, the block holds
// that request until the output register drains.
// The synchronous active-low reset clears the mode, last level, history count and
// pointer and loads the configuration defaults; the history memory is not cleared.
// Configuration writes on i_cfg_* take effect at once and are meant to be done while idle.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_change_monitor
    import blcm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: level_percent[7:0], is_charging[8], timestamp[40:9], history_index[47:41]
    input  wire logic [47:0] s_axis_tdata,
    // tuser: req_type
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: accepted[0], notify[1], mode[3:2], period[35:4], level_now[43:36],
    // stored_entries[51:44], entry_found[52], entry_percent[59:53],
    // entry_charging[60], entry_timestamp[92:61], zero fill[95:93]
    output logic [95:0]      m_axis_tdata
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int WW = ((CW > 7) ? CW : 7) + 2;
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

    t_cfg w_cfg;

    blcm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Sequencer and request holding registers.
    t_state r_state, n_state;
    t_req        r_req;
    logic [7:0]  r_level_in;
    logic        r_chg_in;
    logic [31:0] r_ts_in;
    logic [6:0]  r_idx_in;

    // Architectural state.
    t_mode         r_mode;
    logic [7:0]    r_last_level;
    logic          r_last_chg;
    logic [AW-1:0] r_wp;
    logic [CW-1:0] r_total;

    // Result register.
    logic        r_out_valid;
    logic        r_res_accepted;
    logic        r_res_notify;
    t_mode       r_res_mode;
    logic [31:0] r_res_interval;
    logic [7:0]  r_res_level;
    logic [7:0]  r_res_count;
    logic        r_res_found;
    logic [6:0]  r_res_pct;
    logic        r_res_chg;
    logic [31:0] r_res_ts;

    logic w_accept;
    logic w_load;
    logic w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_load        = (r_state == ST_EXEC) && w_out_free;
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    // Read address: the requested entry for a history read, the newest one for a report.
    logic [WW-1:0] w_sum;
    logic [WW-1:0] w_wrap;
    logic [AW-1:0] w_pos;
    logic [AW-1:0] w_prev;
    logic [AW-1:0] w_raddr;

    assign w_sum  = WW'(r_wp) + WW'(HISTORY_DEPTH) - WW'(r_total) + WW'(s_axis_tdata[47:41]);
    assign w_wrap = (w_sum >= WW'(HISTORY_DEPTH)) ? (w_sum - WW'(HISTORY_DEPTH)) : w_sum;
    assign w_pos  = w_wrap[AW-1:0];
    assign w_prev = (r_wp == '0) ? LAST_ADDR : (r_wp - AW'(1));
    assign w_raddr = (t_req'(s_axis_tuser) == REQ_READ) ? w_pos : w_prev;

    logic                w_ram_we;
    logic [ENTRY_W-1:0]  w_wdata;
    logic [ENTRY_W-1:0]  w_rdata;

    blcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Entry layout: percent in the low bits, then the flag, then the timestamp.
    logic [6:0]  w_e_pct;
    logic        w_e_chg;
    logic [31:0] w_e_ts;
    assign w_e_pct = w_rdata[ENTRY_PCT_W-1:0];
    assign w_e_chg = w_rdata[ENTRY_PCT_W];
    assign w_e_ts  = w_rdata[ENTRY_W-1:ENTRY_PCT_W+1];
    assign w_wdata = {r_ts_in, r_chg_in, r_level_in[6:0]};

    // Report evaluation.
    logic       w_is_report;
    logic       w_valid;
    logic [6:0] w_pct;
    logic       w_repeat;
    logic       w_append;
    t_mode      w_new_mode;
    logic [6:0] w_last7;
    logic [6:0] w_diff;
    logic       w_notify;

    assign w_is_report = (r_req == REQ_REPORT);
    assign w_pct       = r_level_in[6:0];
    assign w_valid     = w_is_report && !r_level_in[7] && (r_level_in <= 8'(LEVEL_MAX));
    assign w_repeat    = (r_total != '0) && (w_e_pct == w_pct) && (w_e_chg == r_chg_in);
    assign w_append    = w_valid && !w_repeat;
    assign w_ram_we    = w_load && w_append;

    always_comb begin
        if (r_chg_in) begin
            w_new_mode = MODE_CHARGING;
        end else if (r_level_in <= 8'(LOW_LEVEL_LIMIT)) begin
            w_new_mode = MODE_LOW;
        end else begin
            w_new_mode = MODE_NORMAL;
        end
    end

    assign w_last7  = r_last_level[6:0];
    assign w_diff   = (w_pct >= w_last7) ? (w_pct - w_last7) : (w_last7 - w_pct);
    assign w_notify = (r_last_level != NO_LEVEL)
                   && ((w_diff >= mode_threshold(w_cfg, w_new_mode)) || (r_chg_in != r_last_chg));

    // Next architectural state.
    t_mode         n_mode;
    logic [7:0]    n_last_level;
    logic          n_last_chg;
    logic [AW-1:0] n_wp;
    logic [CW-1:0] n_total;

    always_comb begin
        n_mode       = r_mode;
        n_last_level = r_last_level;
        n_last_chg   = r_last_chg;
        n_wp         = r_wp;
        n_total      = r_total;
        if (w_valid) begin
            n_mode       = w_new_mode;
            n_last_level = r_level_in;
            n_last_chg   = r_chg_in;
            if (w_append) begin
                n_wp = (r_wp == LAST_ADDR) ? '0 : (r_wp + AW'(1));
                if (r_total != CW'(HISTORY_DEPTH)) begin
                    n_total = r_total + CW'(1);
                end
            end
        end
    end

    // History read lookup.
    logic          w_found;
    logic [CW+7:0] w_count_ext;
    assign w_found     = !w_is_report && (WW'(r_idx_in) < WW'(r_total));
    assign w_count_ext = {8'd0, n_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= MODE_NORMAL;
            r_last_level <= NO_LEVEL;
            r_last_chg   <= 1'b0;
            r_wp         <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_mode       <= n_mode;
                r_last_level <= n_last_level;
                r_last_chg   <= n_last_chg;
                r_wp         <= n_wp;
                r_total      <= n_total;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req      <= t_req'(s_axis_tuser);
            r_level_in <= s_axis_tdata[7:0];
            r_chg_in   <= s_axis_tdata[8];
            r_ts_in    <= s_axis_tdata[40:9];
            r_idx_in   <= s_axis_tdata[47:41];
        end
        if (w_load) begin
            r_res_accepted <= w_valid;
            r_res_notify   <= w_valid && w_notify;
            r_res_mode     <= n_mode;
            r_res_interval <= mode_interval(w_cfg, n_mode);
            r_res_level    <= n_last_level;
            r_res_count    <= w_count_ext[7:0];
            r_res_found    <= w_found;
            r_res_pct      <= w_found ? w_e_pct : 7'd0;
            r_res_chg      <= w_found ? w_e_chg : 1'b0;
            r_res_ts       <= w_found ? w_e_ts : 32'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_res_ts, r_res_chg, r_res_pct, r_res_found,
                            r_res_count, r_res_level, r_res_interval, r_res_mode,
                            r_res_notify, r_res_accepted};

`ifndef SYNTHESIS
    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(HISTORY_DEPTH))
        else $error("history count exceeds depth");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execution");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !(r_out_valid && !m_axis_tready))
        else $error("result register overwritten while stalled");

    a_write_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == ST_EXEC) && (r_req == REQ_REPORT)))
        else $error("history write outside a report");

    a_level_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_valid) |=> (!r_res_level[7] && (r_res_level <= 8'(LEVEL_MAX))))
        else $error("accepted report left an out of range level");
`endif

endmodule

`default_nettype wire
